/* rtl/bmpd_pkg.sv */
// ----------------------------------------------------------------------------
// BMP decoder package
// Result record and status codes shared by the parser, the output buffer and
// the top level.
// ----------------------------------------------------------------------------
package bmpd_pkg;

	// Status codes carried with every result.
	localparam logic [2:0] ST_PIXEL      = 3'd0;
	localparam logic [2:0] ST_SHORT      = 3'd1;
	localparam logic [2:0] ST_SIGNATURE  = 3'd2;
	localparam logic [2:0] ST_HDR_SIZE   = 3'd3;
	localparam logic [2:0] ST_COMPRESSED = 3'd4;
	localparam logic [2:0] ST_DEPTH      = 3'd5;
	localparam logic [2:0] ST_DIMENSION  = 3'd6;
	localparam logic [2:0] ST_TRUNCATED  = 3'd7;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] column;
		logic [11:0] image_row;
		logic        last_pixel;
	} result_t;

endpackage

/* rtl/bmpd_parser.sv */
// ----------------------------------------------------------------------------
// BMP byte parser
// Gathers the header fields, checks them after the last header byte, skips to
// the pixel data and builds one pixel result for every colour triple, or one error result.
// ----------------------------------------------------------------------------
module bmpd_parser
	import bmpd_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  file_byte,
	input  logic        first_of_file,
	input  logic [31:0] file_size,
	output logic        res_valid,
	output result_t     res
);

	localparam int W_BITS = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
	localparam int S_BITS = W_BITS + 2;
	localparam int P_BITS = S_BITS + H_BITS;
	localparam int N_BITS = (P_BITS > 32) ? P_BITS + 1 : 33;

	// Header byte positions at which a field is complete or a step is taken.
	localparam logic [31:0] POS_SIG_B     = 32'd0;
	localparam logic [31:0] POS_SIG_M     = 32'd1;
	localparam logic [31:0] POS_OFFSET    = 32'd13;
	localparam logic [31:0] POS_HDR_SIZE  = 32'd17;
	localparam logic [31:0] POS_WIDTH     = 32'd21;
	localparam logic [31:0] POS_HEIGHT    = 32'd25;
	localparam logic [31:0] POS_DEPTH     = 32'd29;
	localparam logic [31:0] POS_ROW_BYTES = 32'd30;
	localparam logic [31:0] POS_STRIDE    = 32'd31;
	localparam logic [31:0] POS_AREA      = 32'd32;
	localparam logic [31:0] POS_LAST      = 32'd33;

	localparam logic [7:0]  CHAR_B        = 8'h42;
	localparam logic [7:0]  CHAR_M        = 8'h4D;
	localparam logic [31:0] MIN_FILE_SIZE = 32'd54;
	localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
	localparam logic [15:0] DEPTH_24      = 16'd24;
	localparam logic [15:0] DEPTH_32      = 16'd32;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_PIXEL  = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	phase_t              phase_q, phase_d, cur_phase;
	logic [31:0]         pos_q, pos_d, cur_pos;
	logic [31:0]         offset_q, offset_d;
	logic [31:0]         hword_q, hword_d;
	logic [W_BITS-1:0]   width_q, width_d;
	logic [H_BITS-1:0]   height_q, height_d;
	logic                top_down_q, top_down_d;
	logic                bpp4_q, bpp4_d;
	logic                f_sig_q, f_sig_d, f_hsize_q, f_hsize_d;
	logic                f_depth_q, f_depth_d, f_dim_q, f_dim_d;
	logic [S_BITS-1:0]   row_bytes_q, row_bytes_d;
	logic [S_BITS-1:0]   stride_q, stride_d;
	logic [P_BITS-1:0]   area_q, area_d;
	logic [S_BITS-1:0]   rbc_q, rbc_d, rbc_inc;
	logic [H_BITS-1:0]   rows_q, rows_d;
	logic [W_BITS-1:0]   col_q, col_d;
	logic [1:0]          bip_q, bip_d;
	logic [7:0]          blue_q, blue_d, green_q, green_d;

	logic [31:0]         word;
	logic [31:0]         height_mag;
	logic [N_BITS-1:0]   need;
	logic                f_short, f_comp, f_trunc, pix_go, bip_wrap, last;
	logic [H_BITS-1:0]   row_out;
	logic                res_valid_c;
	result_t             res_c;

	always_comb begin
		cur_phase  = first_of_file ? PH_HEADER : phase_q;
		cur_pos    = first_of_file ? '0 : pos_q;
		word       = {file_byte, hword_q[31:8]};
		height_mag = word[31] ? (~word + 32'd1) : word;
		need       = N_BITS'(offset_q) + N_BITS'(area_q);
		rbc_inc    = rbc_q + S_BITS'(1);
		bip_wrap   = bpp4_q ? (bip_q == 2'd3) : (bip_q == 2'd2);
		last       = ((rows_q + H_BITS'(1)) == height_q) && ((col_q + W_BITS'(1)) == width_q);
		row_out    = top_down_q ? rows_q : (height_q - H_BITS'(1) - rows_q);

		phase_d     = cur_phase;
		pos_d       = cur_pos;
		offset_d    = offset_q;
		hword_d     = hword_q;
		width_d     = width_q;
		height_d    = height_q;
		top_down_d  = first_of_file ? 1'b0 : top_down_q;
		bpp4_d      = bpp4_q;
		f_sig_d     = first_of_file ? 1'b0 : f_sig_q;
		f_hsize_d   = first_of_file ? 1'b0 : f_hsize_q;
		f_depth_d   = first_of_file ? 1'b0 : f_depth_q;
		f_dim_d     = first_of_file ? 1'b0 : f_dim_q;
		row_bytes_d = row_bytes_q;
		stride_d    = stride_q;
		area_d      = area_q;
		rbc_d       = rbc_q;
		rows_d      = rows_q;
		col_d       = col_q;
		bip_d       = bip_q;
		blue_d      = blue_q;
		green_d     = green_q;
		f_short     = 1'b0;
		f_comp      = 1'b0;
		f_trunc     = 1'b0;
		pix_go      = 1'b0;
		res_valid_c = 1'b0;
		res_c       = '0;

		case (cur_phase)
			PH_HEADER: begin
				hword_d = word;
				pos_d   = cur_pos + 32'd1;
				if (cur_pos == POS_SIG_B && file_byte != CHAR_B)
					f_sig_d = 1'b1;
				if (cur_pos == POS_SIG_M && file_byte != CHAR_M)
					f_sig_d = 1'b1;
				if (cur_pos == POS_OFFSET) begin
					offset_d = word;
					if (word < MIN_FILE_SIZE)
						f_dim_d = 1'b1;
				end
				if (cur_pos == POS_HDR_SIZE && word != INFO_HDR_SIZE)
					f_hsize_d = 1'b1;
				if (cur_pos == POS_WIDTH) begin
					if (word[31] || word == '0 || word > 32'(MAX_WIDTH))
						f_dim_d = 1'b1;
					else
						width_d = word[W_BITS-1:0];
				end
				if (cur_pos == POS_HEIGHT) begin
					top_down_d = word[31];
					if (height_mag == '0 || height_mag > 32'(MAX_HEIGHT))
						f_dim_d = 1'b1;
					else
						height_d = height_mag[H_BITS-1:0];
				end
				if (cur_pos == POS_DEPTH) begin
					if (word[31:16] == DEPTH_24)
						bpp4_d = 1'b0;
					else if (word[31:16] == DEPTH_32)
						bpp4_d = 1'b1;
					else
						f_depth_d = 1'b1;
				end
				// The size of the pixel area is built up over the last few
				// header bytes, one short step per byte.
				if (cur_pos == POS_ROW_BYTES)
					row_bytes_d = bpp4_q ? {width_q, 2'b00}
					                     : (S_BITS'(width_q) + {1'b0, width_q, 1'b0});
				if (cur_pos == POS_STRIDE)
					stride_d = (row_bytes_q + S_BITS'(3)) & ~S_BITS'(3);
				if (cur_pos == POS_AREA)
					area_d = P_BITS'(stride_q) * P_BITS'(height_q);
				if (cur_pos == POS_LAST) begin
					f_comp  = (word != '0);
					f_short = (file_size < MIN_FILE_SIZE);
					f_trunc = !(f_comp || f_short || f_sig_d || f_hsize_d || f_depth_d
					            || f_dim_d) && (need > N_BITS'(file_size));
					if (f_short || f_sig_d || f_hsize_d || f_comp || f_depth_d || f_dim_d
					    || f_trunc) begin
						phase_d     = PH_DONE;
						res_valid_c = 1'b1;
						if (f_short)
							res_c.status = ST_SHORT;
						else if (f_sig_d)
							res_c.status = ST_SIGNATURE;
						else if (f_hsize_d)
							res_c.status = ST_HDR_SIZE;
						else if (f_comp)
							res_c.status = ST_COMPRESSED;
						else if (f_depth_d)
							res_c.status = ST_DEPTH;
						else if (f_dim_d)
							res_c.status = ST_DIMENSION;
						else
							res_c.status = ST_TRUNCATED;
					end else begin
						phase_d = PH_SKIP;
						rbc_d   = '0;
						rows_d  = '0;
						col_d   = '0;
						bip_d   = '0;
					end
				end
			end
			PH_SKIP: begin
				if (cur_pos != offset_q) begin
					pos_d = cur_pos + 32'd1;
				end else begin
					phase_d = PH_PIXEL;
					pix_go  = 1'b1;
				end
			end
			PH_PIXEL: begin
				pix_go = 1'b1;
			end
			default: begin
			end
		endcase

		if (pix_go) begin
			// Bytes past the colour data of a row are padding and are dropped.
			if (rbc_q < row_bytes_q) begin
				case (bip_q)
					2'd0: blue_d = file_byte;
					2'd1: green_d = file_byte;
					2'd2: begin
						res_valid_c       = 1'b1;
						res_c.status      = ST_PIXEL;
						res_c.red         = file_byte;
						res_c.green       = green_q;
						res_c.blue        = blue_q;
						res_c.column      = 12'(col_q);
						res_c.image_row   = 12'(row_out);
						res_c.last_pixel  = last;
						if (last)
							phase_d = PH_DONE;
					end
					default: begin
					end
				endcase
				bip_d = bip_wrap ? 2'd0 : (bip_q + 2'd1);
				if (bip_wrap)
					col_d = col_q + W_BITS'(1);
			end
			if (rbc_inc >= stride_q) begin
				rbc_d  = '0;
				rows_d = rows_q + H_BITS'(1);
				col_d  = '0;
			end else begin
				rbc_d = rbc_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			offset_q    <= '0;
			hword_q     <= '0;
			width_q     <= '0;
			height_q    <= '0;
			top_down_q  <= 1'b0;
			bpp4_q      <= 1'b0;
			f_sig_q     <= 1'b0;
			f_hsize_q   <= 1'b0;
			f_depth_q   <= 1'b0;
			f_dim_q     <= 1'b0;
			row_bytes_q <= '0;
			stride_q    <= '0;
			area_q      <= '0;
			rbc_q       <= '0;
			rows_q      <= '0;
			col_q       <= '0;
			bip_q       <= '0;
			blue_q      <= '0;
			green_q     <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			offset_q    <= offset_d;
			hword_q     <= hword_d;
			width_q     <= width_d;
			height_q    <= height_d;
			top_down_q  <= top_down_d;
			bpp4_q      <= bpp4_d;
			f_sig_q     <= f_sig_d;
			f_hsize_q   <= f_hsize_d;
			f_depth_q   <= f_depth_d;
			f_dim_q     <= f_dim_d;
			row_bytes_q <= row_bytes_d;
			stride_q    <= stride_d;
			area_q      <= area_d;
			rbc_q       <= rbc_d;
			rows_q      <= rows_d;
			col_q       <= col_d;
			bip_q       <= bip_d;
			blue_q      <= blue_d;
			green_q     <= green_d;
		end
	end

	assign res_valid = accept && res_valid_c;
	assign res       = res_c;

endmodule

/* rtl/bmpd_out_buf.sv */
// ----------------------------------------------------------------------------
// BMP decoder output buffer
// Result register with a skid entry, so that a result can be taken in while
// the one before it is still held by a stalled receiver.
// ----------------------------------------------------------------------------
module bmpd_out_buf
	import bmpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load_valid,
	input  result_t load,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    out_v_q, skid_v_q;
	result_t out_q, skid_q;
	logic    slot_free, load_out, load_skid;

	always_comb begin
		slot_free = !out_v_q || !out_stall;
		load_out  = slot_free && (skid_v_q || load_valid);
		load_skid = !skid_v_q && load_valid && !slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (slot_free)
				out_v_q <= skid_v_q || load_valid;
			if (skid_v_q && slot_free)
				skid_v_q <= 1'b0;
			else if (load_skid)
				skid_v_q <= 1'b1;
		end
	end

	// The skid entry, when full, is always older than anything arriving.
	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= skid_v_q ? skid_q : load;
		if (load_skid)
			skid_q <= load;
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

/* rtl/bmp_pixel_stream_decoder.sv */
// ----------------------------------------------------------------------------
// BMP pixel stream decoder
// Decodes an uncompressed 24 or 32 bit BMP file, fed one byte per transfer,
// into pixels with their coordinates, or into a single header error result.
//
//   channel   direction  handshake            payload
//   config    in         file_size_we         file_size_data
//   bytes     in         in_valid / in_stall  file_byte, first_of_file
//   results   out        out_valid / out_stall status, red, green, blue,
//                                             column, image_row, last_pixel
//
// One byte is taken in every cycle while in_stall is low; each byte updates
// the parser registers and its result, if any, is registered in the buffer.
// Reset puts the parser at byte zero of a file and clears the size register.
// A stalled result is held in the output register and the next result goes to
// a skid entry; bytes are stalled only while that entry is full.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder
	import bmpd_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        file_size_we,
	input  logic [31:0] file_size_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  file_byte,
	input  logic        first_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [11:0] column,
	output logic [11:0] image_row,
	output logic        last_pixel
);

	logic [31:0] file_size_q;
	logic        accept, res_valid, buf_full;
	result_t     res, out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			file_size_q <= '0;
		else if (file_size_we)
			file_size_q <= file_size_data;
	end

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	bmpd_parser #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.file_byte     (file_byte),
		.first_of_file (first_of_file),
		.file_size     (file_size_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	bmpd_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (res_valid),
		.load       (res),
		.full       (buf_full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	assign status     = out_data.status;
	assign red        = out_data.red;
	assign green      = out_data.green;
	assign blue       = out_data.blue;
	assign column     = out_data.column;
	assign image_row  = out_data.image_row;
	assign last_pixel = out_data.last_pixel;

endmodule
